### rtl/lpht_pkg.sv
// Shared types and constants for the linear probing hash table core.
// Holds field widths, status and operation codes, slot entry layout and FSM states.
// No dependencies.
package lpht_pkg;

  localparam int unsigned KEY_W    = 31;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 32;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_SEARCH = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_FOUND     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_DONE
  } state_t;

endpackage

### rtl/linear_probing_hash_table_core.sv
// Linear probing hash table core: top level, control FSM and probe datapath.
// Depends on lpht_pkg, lpht_mod (remainder unit) and lpht_mem (slot store).
//
//   channel | handshake           | beat payload
//   --------+---------------------+-------------------------------------------
//   in      | in_valid / in_ready | operation, key
//   out     | out_valid/out_ready | status, slot, home_slot, total_collisions
//
// Steps: one item at a time. Accept, hashing (remainder by reciprocal
// multiplication), probing (one slot store read a cycle, reads issued back
// to back), then commit.
// Reset: a clearing pass writes every slot empty; in_ready stays low until
// it ends.
// Stalls: a result waits in the output register; the next beat is taken and
// worked on meanwhile, holding only at commit until the output is free.
module linear_probing_hash_table_core
  import lpht_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                operation,
  input  logic [KEY_W-1:0]    key,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [SLOT_W-1:0]   slot,
  output logic [SLOT_W-1:0]   home_slot,
  output logic [COUNT_W-1:0]  total_collisions
);

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_ENTRIES - 1);

  // Low SLOT_W bits of a slot number, zero-extended for small tables.
  function automatic logic [SLOT_W-1:0] slot_field(input logic [AW-1:0] s);
    logic [SLOT_W+AW-1:0] ext;
    ext = {{SLOT_W{1'b0}}, s};
    return ext[SLOT_W-1:0];
  endfunction

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  state_t state, state_next;

  // Item under work
  op_t              op;
  logic [KEY_W-1:0] key_r;
  logic [AW-1:0]    home;

  // Probe pipeline: issue_slot is the next read, eval_slot the read whose
  // data arrives this cycle when pend is set.
  logic [AW-1:0] issue_slot;
  logic [AW-1:0] eval_slot;
  logic [CW-1:0] n_issue;
  logic [CW-1:0] n_eval;
  logic          pend;

  logic [AW-1:0]      clr_idx;
  logic [COUNT_W-1:0] coll;

  status_t       fin_status;
  logic [AW-1:0] fin_slot;

  status_t       res_status;
  logic [AW-1:0] res_slot;
  logic [AW-1:0] res_home;

  // Remainder unit and slot store hookup
  logic          in_take;
  logic          mod_done;
  logic [AW-1:0] mod_rem;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  entry_t        mem_wdata;
  logic          mem_re;
  entry_t        mem_rdata;

  logic hit;
  logic last_eval;
  logic out_free;

  lpht_mod #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_mod (
    .clk  (clk),
    .rst  (rst),
    .start(in_take),
    .key  (key),
    .done (mod_done),
    .rem  (mod_rem)
  );

  lpht_mem #(
    .DEPTH(TABLE_ENTRIES)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(issue_slot),
    .rdata(mem_rdata)
  );

  assign in_take  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // Evaluate the slot whose read data is back: an insert stops at the first
  // empty slot, a search at the first valid slot holding the key.
  always_comb begin
    hit = 1'b0;
    if (pend) begin
      unique case (op)
        OP_INSERT: hit = !mem_rdata.valid;
        OP_SEARCH: hit = mem_rdata.valid && (mem_rdata.key == key_r);
        default:   hit = 1'b0;
      endcase
    end
  end

  assign last_eval = pend && (n_eval == CW'(TABLE_ENTRIES - 1));

  // Next state and control
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = clr_idx;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_idx == LAST_SLOT) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_HASH;
        end
      end
      S_HASH: begin
        if (mod_done) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        // Keep one read in flight; stop issuing once every slot has been read.
        mem_re = !hit && (n_issue != CW'(TABLE_ENTRIES));
        if (hit && op == OP_INSERT) begin
          mem_we    = 1'b1;
          mem_waddr = eval_slot;
          mem_wdata = '{valid: 1'b1, key: key_r};
        end
        if (hit || last_eval) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx   <= '0;
      pend      <= 1'b0;
      coll      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (state == S_PROBE) begin
        pend <= mem_re;
        // Count each occupied slot an insert walks past, saturating.
        if (pend && !hit && op == OP_INSERT && coll != '1) begin
          coll <= coll + 1'b1;
        end
      end else begin
        pend <= 1'b0;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      op    <= op_t'(operation);
      key_r <= key;
    end
    if (state == S_HASH && mod_done) begin
      home       <= mod_rem;
      issue_slot <= mod_rem;
      n_issue    <= '0;
      n_eval     <= '0;
    end
    if (state == S_PROBE) begin
      if (mem_re) begin
        eval_slot  <= issue_slot;
        issue_slot <= wrap_inc(issue_slot);
        n_issue    <= n_issue + 1'b1;
      end
      if (pend) begin
        n_eval <= n_eval + 1'b1;
      end
      if (hit) begin
        fin_status <= (op == OP_INSERT) ? ST_INSERTED : ST_FOUND;
        fin_slot   <= eval_slot;
      end else if (last_eval) begin
        fin_status <= (op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
        fin_slot   <= '0;
      end
    end
    if (state == S_DONE && out_free) begin
      res_status       <= fin_status;
      res_slot         <= fin_slot;
      res_home         <= home;
      total_collisions <= coll;
    end
  end

  assign status    = res_status;
  assign slot      = slot_field(res_slot);
  assign home_slot = slot_field(res_home);

endmodule

### rtl/lpht_mod.sv
// Remainder unit: key modulo TABLE_ENTRIES by reciprocal multiplication.
// Depends on lpht_pkg.
module lpht_mod
  import lpht_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [KEY_W-1:0]                 key,
  output logic                             done,
  output logic [$clog2(TABLE_ENTRIES)-1:0] rem
);

  localparam int unsigned AW      = $clog2(TABLE_ENTRIES);
  localparam int unsigned RECIP_W = 32;
  localparam int unsigned PROD_W  = KEY_W + RECIP_W;
  localparam int unsigned SHIFT   = KEY_W + AW;
  // Rounded-up reciprocal; the quotient taken from the product is exact for
  // every KEY_W-bit key.
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << SHIFT) + 64'(TABLE_ENTRIES) - 64'd1) / 64'(TABLE_ENTRIES);
  localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(RECIP_WIDE);
  localparam logic [AW-1:0]      MOD_LO = AW'(TABLE_ENTRIES);

  logic [PROD_W-1:0] prod;
  logic [AW-1:0]     quo_lo;
  logic [AW-1:0]     key_lo;
  logic [AW-1:0]     quo_mod;
  logic              pend;

  assign prod    = PROD_W'(key) * PROD_W'(RECIP);
  // The remainder fits in AW bits, so only the low AW bits of the quotient
  // times the modulus are needed.
  assign quo_mod = quo_lo * MOD_LO;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      done <= 1'b0;
    end else begin
      pend <= start;
      done <= pend;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_lo <= prod[SHIFT +: AW];
      key_lo <= key[AW-1:0];
    end
    if (pend) begin
      rem <= key_lo - quo_mod;
    end
  end

endmodule

### rtl/lpht_mem.sv
// Slot store: one write port, one read port, registered read data.
// Depends on lpht_pkg for the entry layout.
module lpht_mem
  import lpht_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  entry_t                   wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output entry_t                   rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### dv/linear_probing_hash_table_core_test.sv
// Self-checking testbench for linear_probing_hash_table_core: directed and random beats.
// Predicts every result with a local copy of the table; depends on lpht_pkg and the RTL.
`timescale 1ns / 100ps

module linear_probing_hash_table_core_test;
  import lpht_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 16;
  // Run limit, kept well above the slowest correct run.
  localparam int unsigned CYCLE_LIMIT   = 600000;
  // Settle time after the last result: a full probe walk plus hashing and commit.
  localparam int unsigned DRAIN_CYCLES  = TABLE_ENTRIES + 24;
  localparam int unsigned LONG_HOLD_OFF = 400;

  // One result beat as the table should answer it.
  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [SLOT_W-1:0]   home;
    logic [COUNT_W-1:0]  collisions;
  } answer_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  logic                operation;
  logic [KEY_W-1:0]    key;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [SLOT_W-1:0]   home_slot;
  logic [COUNT_W-1:0]  total_collisions;

  // Local image of the table, updated as each input beat is accepted.
  logic [KEY_W-1:0]    model_keys [TABLE_ENTRIES];
  logic                model_used [TABLE_ENTRIES];
  logic [COUNT_W-1:0]  model_collisions;

  answer_t             pending_answers[$];
  int unsigned         fail_count;
  int unsigned         cycle_count;
  bit                  throttle_on;        // random idling on both channels
  int unsigned         hold_off_request;   // receiver stall length, picked up by the sink

  linear_probing_hash_table_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) i_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .key              (key),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .slot             (slot),
    .home_slot        (home_slot),
    .total_collisions (total_collisions)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Watchdog: end the run if the traffic never drains.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("linear_probing_hash_table_core regression: fail");
    $finish;
  end

  // Walk the table the way the block does and return its answer.
  // Insert: store in the first free slot from home, count each occupied
  // slot passed (saturating). Search: first used slot holding the key.
  function automatic answer_t apply_table_op(op_t op, logic [KEY_W-1:0] k);
    answer_t     a;
    int unsigned probe;
    int unsigned home;
    home         = k % TABLE_ENTRIES;
    probe        = home;
    a.home       = home[SLOT_W-1:0];
    a.slot       = '0;
    if (op == OP_INSERT) begin
      a.status = ST_FULL;
      for (int n = 0; n < TABLE_ENTRIES; n++) begin
        if (!model_used[probe]) begin
          model_keys[probe] = k;
          model_used[probe] = 1'b1;
          a.status          = ST_INSERTED;
          a.slot            = probe[SLOT_W-1:0];
          break;
        end
        if (model_collisions != '1) model_collisions++;
        probe = (probe + 1 == TABLE_ENTRIES) ? 0 : probe + 1;
      end
    end else begin
      a.status = ST_NOT_FOUND;
      for (int n = 0; n < TABLE_ENTRIES; n++) begin
        if (model_used[probe] && model_keys[probe] == k) begin
          a.status = ST_FOUND;
          a.slot   = probe[SLOT_W-1:0];
          break;
        end
        probe = (probe + 1 == TABLE_ENTRIES) ? 0 : probe + 1;
      end
    end
    a.collisions = model_collisions;
    return a;
  endfunction

  // Offer one beat after an optional random gap; hold it until taken, then
  // record what the table should answer. Valid stays high on return so a
  // following beat can go out back to back.
  task automatic send_beat(input op_t op, input logic [KEY_W-1:0] k);
    int unsigned gap;
    gap = 0;
    if (throttle_on) begin
      while ($urandom_range(0, 99) < 26) gap++;
      // Now and then idle long enough to land in a later phase of the probe.
      if ($urandom_range(0, 7) == 0) gap += $urandom_range(1, 32);
    end
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    key       <= k;
    do @(posedge clk); while (!in_ready);
    pending_answers.push_back(apply_table_op(op, k));
  endtask

  // Drop valid and wait until every expected result has been taken.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_answers.size() != 0);
  endtask

  // Result sink: random stalls, plus a long hold-off on request.
  initial begin : sink_drive
    int unsigned hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_request != 0) begin
        hold_left        = hold_off_request;
        hold_off_request = 0;
      end
      if (rst) begin
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (throttle_on && $urandom_range(0, 99) < 26) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare every accepted result beat with the oldest expectation.
  always @(posedge clk) begin : result_check
    answer_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: result beat with nothing expected: status %0d slot %0d home %0d",
                 $time, status, slot, home_slot);
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status);
          fail_count++;
        end
        if (slot !== want.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, want.slot, slot);
          fail_count++;
        end
        if (home_slot !== want.home) begin
          $display("%0t: home_slot expected %0d actual %0d", $time, want.home, home_slot);
          fail_count++;
        end
        if (total_collisions !== want.collisions) begin
          $display("%0t: total_collisions expected %0d actual %0d",
                   $time, want.collisions, total_collisions);
          fail_count++;
        end
      end
    end
  end

  // Searches on an empty table must miss after a full walk.
  task automatic test_empty_search();
    send_beat(OP_SEARCH, '0);
    send_beat(OP_SEARCH, '1);
  endtask

  // Pile keys onto home slot 15 so probes wrap to slot 0 and onward, then
  // look them up, including a miss that walks the whole table.
  task automatic test_wrap_and_collide();
    send_beat(OP_INSERT, '1);
    send_beat(OP_INSERT, 31'd15);
    send_beat(OP_INSERT, 31'd0);
    send_beat(OP_INSERT, 31'd31);
    send_beat(OP_SEARCH, 31'd15);
    send_beat(OP_SEARCH, 31'd31);
    send_beat(OP_SEARCH, '1);
    send_beat(OP_SEARCH, 31'd47);
    send_beat(OP_SEARCH, 31'd1);
  endtask

  // A duplicate key takes a new slot; a search still finds the first copy.
  task automatic test_duplicate_keys();
    send_beat(OP_INSERT, 31'd15);
    send_beat(OP_SEARCH, 31'd15);
  endtask

  // Alternating and top-bit patterns in the key.
  task automatic test_key_patterns();
    send_beat(OP_INSERT, 31'h4000_0000);
    send_beat(OP_INSERT, 31'h2AAA_AAAA);
    send_beat(OP_SEARCH, 31'h5555_5555);
  endtask

  // Fill every remaining slot, then insert into the full table and miss on it.
  task automatic test_table_full();
    int unsigned free_slots;
    free_slots = 0;
    foreach (model_used[i]) if (!model_used[i]) free_slots++;
    repeat (free_slots) send_beat(OP_INSERT, KEY_W'($urandom));
    send_beat(OP_INSERT, 31'd7);
    send_beat(OP_SEARCH, 31'h7FFF_FFF7);
  endtask

  // Mixed traffic: inserts, hits on stored keys, near misses that share a
  // stored key's home slot, and plain random lookups.
  task automatic test_random_traffic(input int unsigned beats);
    int unsigned      pick;
    int unsigned      idx;
    logic [KEY_W-1:0] k;
    repeat (beats) begin
      pick = $urandom_range(0, 99);
      idx  = $urandom_range(0, TABLE_ENTRIES - 1);
      k    = KEY_W'($urandom);
      if ($urandom_range(0, 9) == 0) k = $urandom_range(0, 1) ? '1 : '0;
      if (pick < 30) begin
        send_beat(OP_INSERT, k);
      end else if (pick < 75) begin
        if (model_used[idx]) k = model_keys[idx];
        send_beat(OP_SEARCH, k);
      end else if (pick < 88) begin
        if (model_used[idx]) k = model_keys[idx] ^ (KEY_W'(1) << $urandom_range(SLOT_W, KEY_W - 1));
        send_beat(OP_SEARCH, k);
      end else begin
        send_beat(OP_SEARCH, k);
      end
    end
  endtask

  // Stall the sink for a long stretch while beats keep coming, so the core
  // fills its output register and holds off its input.
  task automatic test_back_pressure();
    hold_off_request = LONG_HOLD_OFF;
    test_random_traffic(12);
  endtask

  // Let every result drain before the next beat goes out.
  task automatic test_drain_pause();
    wait_for_drain();
    test_random_traffic(8);
  endtask

  initial begin
    fail_count       = 0;
    cycle_count      = 0;
    throttle_on      = 1'b1;
    hold_off_request = 0;
    model_collisions = '0;
    foreach (model_used[i]) begin
      model_used[i] = 1'b0;
      model_keys[i] = '0;
    end
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    operation <= OP_INSERT;
    key       <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // in_ready stays low through the clearing pass; send_beat waits it out.
    test_empty_search();
    test_wrap_and_collide();
    test_duplicate_keys();
    test_key_patterns();
    test_table_full();
    test_random_traffic(600);
    test_back_pressure();
    test_drain_pause();
    throttle_on = 1'b0;
    test_random_traffic(400);
    throttle_on = 1'b1;
    test_random_traffic(650);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_answers.size() == 0) begin
      $display("linear_probing_hash_table_core regression: pass");
    end else begin
      $display("linear_probing_hash_table_core regression: fail");
    end
    $finish;
  end

endmodule

### sim.f
rtl/lpht_pkg.sv
rtl/lpht_mod.sv
rtl/lpht_mem.sv
rtl/linear_probing_hash_table_core.sv
dv/linear_probing_hash_table_core_test.sv
